FILE: hw/rtl/opd_pkg.sv
// ----------------------------------------------------------------------------
// opd_pkg
// Shared types and constants for the obstruction pulse detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package opd_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_PERIOD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_MIN      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OBSTRUCTED_AFT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ASLEEP_LEVEL   = 2'd3;

    localparam logic [9:0]  CHECK_PERIOD_RST = 10'd50;
    localparam logic [7:0]  PULSE_MIN_RST    = 8'd3;
    localparam logic [15:0] OBSTRUCTED_RST   = 16'd700;
    localparam logic        ASLEEP_LEVEL_RST = 1'b0;

    localparam logic [1:0] OBS_UNKNOWN    = 2'd0;
    localparam logic [1:0] OBS_CLEAR      = 2'd1;
    localparam logic [1:0] OBS_OBSTRUCTED = 2'd2;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef struct packed {
        logic [9:0]  check_period_ms;
        logic [7:0]  pulse_min;
        logic [15:0] obstructed_after_ms;
        logic        asleep_level;
    } cfg_t;

    typedef struct packed {
        logic command;
        logic line_level;
        logic ms_tick;
        logic reported_state;
    } item_t;

    typedef struct packed {
        logic [1:0] obstruction;
        logic       sensor_present;
        logic       window_closed;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/opd_cfg_regs.sv
// ----------------------------------------------------------------------------
// opd_cfg_regs
// Configuration register file, written through the cfg request channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opd_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire logic [opd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [opd_pkg::CFG_DATA_W-1:0]       cfg_data,
    output opd_pkg::cfg_t                             cfg
);

    opd_pkg::cfg_t cfg_reg;
    opd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                opd_pkg::REG_CHECK_PERIOD:   cfg_next.check_period_ms     = cfg_data[9:0];
                opd_pkg::REG_PULSE_MIN:      cfg_next.pulse_min           = cfg_data[7:0];
                opd_pkg::REG_OBSTRUCTED_AFT: cfg_next.obstructed_after_ms = cfg_data[15:0];
                opd_pkg::REG_ASLEEP_LEVEL:   cfg_next.asleep_level        = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_period_ms     <= opd_pkg::CHECK_PERIOD_RST;
            cfg_reg.pulse_min           <= opd_pkg::PULSE_MIN_RST;
            cfg_reg.obstructed_after_ms <= opd_pkg::OBSTRUCTED_RST;
            cfg_reg.asleep_level        <= opd_pkg::ASLEEP_LEVEL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/opd_classifier.sv
// ----------------------------------------------------------------------------
// opd_classifier
// Edge/window/asleep-timer state and the per-sample classification logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opd_classifier #(
    parameter int unsigned AGE_W = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire opd_pkg::item_t  item,
    input  wire opd_pkg::cfg_t   cfg,
    output opd_pkg::result_t     result
);

    // compare width: one bit above the wider of the age timer and the limit
    localparam int unsigned CMP_W = ((AGE_W > 16) ? AGE_W : 16) + 1;

    logic [9:0]       window_reg,  window_next;
    logic [7:0]       edge_reg,    edge_next;
    logic [AGE_W-1:0] age_reg,     age_next;
    logic             prev_reg,    prev_next;
    logic [1:0]       obs_reg,     obs_next;
    logic             present_reg, present_next;
    logic             closed;

    logic [9:0]       window_inc;
    logic [7:0]       edge_inc;
    logic [AGE_W-1:0] age_inc;
    logic             fall;
    logic             is_sample;
    logic [CMP_W-1:0] age_ext;
    logic [CMP_W-1:0] limit_ext;

    always_comb
    begin
        is_sample  = (item.command == opd_pkg::CMD_SAMPLE);
        fall       = prev_reg && !item.line_level && (edge_reg != 8'hFF);
        edge_inc   = edge_reg + {7'd0, fall};
        window_inc = window_reg + {9'd0, (item.ms_tick && (window_reg != 10'h3FF))};
        age_inc    = age_reg + {{(AGE_W-1){1'b0}}, (item.ms_tick && !(&age_reg))};
        age_ext    = {{(CMP_W-AGE_W){1'b0}}, age_inc};
        limit_ext  = {{(CMP_W-16){1'b0}}, cfg.obstructed_after_ms};

        window_next  = window_reg;
        edge_next    = edge_reg;
        age_next     = age_reg;
        prev_next    = prev_reg;
        obs_next     = obs_reg;
        present_next = present_reg;
        closed       = 1'b0;

        if (!is_sample)
        begin
            if (!present_reg)
                obs_next = item.reported_state ? opd_pkg::OBS_OBSTRUCTED
                                               : opd_pkg::OBS_CLEAR;
        end
        else
        begin
            prev_next   = item.line_level;
            edge_next   = edge_inc;
            window_next = window_inc;
            age_next    = age_inc;
            if (window_inc > cfg.check_period_ms)
            begin
                closed      = 1'b1;
                window_next = '0;
                edge_next   = '0;
                if (edge_inc > cfg.pulse_min)
                begin
                    obs_next     = opd_pkg::OBS_CLEAR;
                    present_next = 1'b1;
                end
                else if (edge_inc == 8'd0)
                begin
                    if (item.line_level == cfg.asleep_level)
                        age_next = '0;
                    else if (age_ext > limit_ext)
                        obs_next = opd_pkg::OBS_OBSTRUCTED;
                end
            end
        end

        result.obstruction    = obs_next;
        result.sensor_present = present_next;
        result.window_closed  = closed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= '0;
            edge_reg    <= '0;
            age_reg     <= '0;
            prev_reg    <= 1'b1;
            obs_reg     <= opd_pkg::OBS_UNKNOWN;
            present_reg <= 1'b0;
        end
        else if (step)
        begin
            window_reg  <= window_next;
            edge_reg    <= edge_next;
            age_reg     <= age_next;
            prev_reg    <= prev_next;
            obs_reg     <= obs_next;
            present_reg <= present_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/obstruction_pulse_detector.sv
// An accepted request is held in the input reg, then its result in the result reg.
// Throughput: one request per cycle while the output is not stalled; set by the
// combinational state update between the input register and the result register.
// Reset: asynchronous, active low; config returns to defaults, counters clear,
// obstruction reads unknown, line assumed idle high.
// ----------------------------------------------------------------------------
// obstruction_pulse_detector
// Classifies a safety-beam line from line samples and protocol reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obstruction_pulse_detector #(
    parameter int unsigned ASLEEP_TIMER_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output      logic                            in_stall,
    input  wire logic                            command,
    input  wire logic                            line_level,
    input  wire logic                            ms_tick,
    input  wire logic                            reported_state,

    output      logic                            out_valid,
    input  wire logic                            out_stall,
    output      logic [1:0]                      obstruction,
    output      logic                            sensor_present,
    output      logic                            window_closed,

    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [opd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [opd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    opd_pkg::cfg_t    cfg;
    opd_pkg::item_t   item_reg;
    opd_pkg::result_t res;
    opd_pkg::result_t res_reg;
    logic             s1_valid_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             advance;
    logic             take_in;

    assign cfg_ready = 1'b1;

    opd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign take_in  = in_valid && !in_stall;

    opd_classifier #(
        .AGE_W (ASLEEP_TIMER_BITS)
    ) u_cls (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg.command        <= command;
            item_reg.line_level     <= line_level;
            item_reg.ms_tick        <= ms_tick;
            item_reg.reported_state <= reported_state;
        end
        if (advance)
            res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign obstruction    = res_reg.obstruction;
    assign sensor_present = res_reg.sensor_present;
    assign window_closed  = res_reg.window_closed;

endmodule

`default_nettype wire

FILE: test/opd_checker.sv
// ----------------------------------------------------------------------------
// opd_checker
// Watches the request, result and register channels of the obstruction
// pulse detector, keeps its own model of the line classifier and compares
// every result, field by field, with the status it predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opd_checker #(
    parameter int unsigned ASLEEP_TIMER_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            command,
    input  logic                            line_level,
    input  logic                            ms_tick,
    input  logic                            reported_state,

    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [1:0]                      obstruction,
    input  logic                            sensor_present,
    input  logic                            window_closed,

    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [opd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [opd_pkg::CFG_DATA_W-1:0]  cfg_data,

    output int                              fail_count,
    output int                              pending
);

    localparam logic [9:0]                   WINDOW_TOP = '1;
    localparam logic [7:0]                   FALLS_TOP  = '1;
    localparam logic [ASLEEP_TIMER_BITS-1:0] AGE_TOP    = '1;

    opd_pkg::cfg_t                shadow_cfg;
    logic [9:0]                   win_ms;
    logic [7:0]                   falls;
    logic [ASLEEP_TIMER_BITS-1:0] asleep_age;
    logic                         last_level;
    logic [1:0]                   obs_state;
    logic                         seen_sensor;

    opd_pkg::result_t status_due[$];
    opd_pkg::item_t   req_now;
    opd_pkg::result_t want;
    opd_pkg::result_t got;

    // Advances the classifier by one request and returns the status it reports.
    function automatic opd_pkg::result_t classify(input opd_pkg::item_t req);
        opd_pkg::result_t res;
        res.window_closed = 1'b0;
        if (req.command != opd_pkg::CMD_SAMPLE)
        begin
            // reports only count while no pulsing sensor has been seen
            if (!seen_sensor)
                obs_state = req.reported_state ? opd_pkg::OBS_OBSTRUCTED
                                               : opd_pkg::OBS_CLEAR;
        end
        else
        begin
            if (last_level && !req.line_level && falls != FALLS_TOP)
                falls = falls + 8'd1;
            last_level = req.line_level;
            if (req.ms_tick)
            begin
                if (win_ms != WINDOW_TOP)
                    win_ms = win_ms + 10'd1;
                if (asleep_age != AGE_TOP)
                    asleep_age = asleep_age + 1'b1;
            end
            // tested on every sample, so a lowered period closes without a tick
            if (win_ms > shadow_cfg.check_period_ms)
            begin
                res.window_closed = 1'b1;
                if (falls > shadow_cfg.pulse_min)
                begin
                    obs_state   = opd_pkg::OBS_CLEAR;
                    seen_sensor = 1'b1;
                end
                else if (falls == 8'd0)
                begin
                    if (req.line_level == shadow_cfg.asleep_level)
                        asleep_age = '0;
                    else if (asleep_age > shadow_cfg.obstructed_after_ms)
                        obs_state = opd_pkg::OBS_OBSTRUCTED;
                end
                win_ms = '0;
                falls  = '0;
            end
        end
        res.obstruction    = obs_state;
        res.sensor_present = seen_sensor;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_cfg.check_period_ms     = opd_pkg::CHECK_PERIOD_RST;
            shadow_cfg.pulse_min           = opd_pkg::PULSE_MIN_RST;
            shadow_cfg.obstructed_after_ms = opd_pkg::OBSTRUCTED_RST;
            shadow_cfg.asleep_level        = opd_pkg::ASLEEP_LEVEL_RST;
            win_ms      = '0;
            falls       = '0;
            asleep_age  = '0;
            last_level  = 1'b1;
            obs_state   = opd_pkg::OBS_UNKNOWN;
            seen_sensor = 1'b0;
            status_due.delete();
            fail_count  = 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    opd_pkg::REG_CHECK_PERIOD:
                        shadow_cfg.check_period_ms = cfg_data[9:0];
                    opd_pkg::REG_PULSE_MIN:
                        shadow_cfg.pulse_min = cfg_data[7:0];
                    opd_pkg::REG_OBSTRUCTED_AFT:
                        shadow_cfg.obstructed_after_ms = cfg_data[15:0];
                    opd_pkg::REG_ASLEEP_LEVEL:
                        shadow_cfg.asleep_level = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                req_now.command        = command;
                req_now.line_level     = line_level;
                req_now.ms_tick        = ms_tick;
                req_now.reported_state = reported_state;
                status_due.push_back(classify(req_now));
            end

            if (out_valid && !out_stall)
            begin
                got.obstruction    = obstruction;
                got.sensor_present = sensor_present;
                got.window_closed  = window_closed;
                if (status_due.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = status_due.pop_front();
                    if (got.obstruction !== want.obstruction)
                    begin
                        $error("obstruction: expected %0d, got %0d",
                               want.obstruction, got.obstruction);
                        fail_count++;
                    end
                    if (got.sensor_present !== want.sensor_present)
                    begin
                        $error("sensor_present: expected %0d, got %0d",
                               want.sensor_present, got.sensor_present);
                        fail_count++;
                    end
                    if (got.window_closed !== want.window_closed)
                    begin
                        $error("window_closed: expected %0d, got %0d",
                               want.window_closed, got.window_closed);
                        fail_count++;
                    end
                end
            end

            pending <= status_due.size();
        end
    end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the obstruction pulse detector: a directed opening, random
// pulsing / steady / asleep / report sequences under several register
// settings and idle patterns, edge-counter saturation runs, a period test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic                            command;
    logic                            line_level;
    logic                            ms_tick;
    logic                            reported_state;
    logic                            out_valid;
    logic                            out_stall;
    logic [1:0]                      obstruction;
    logic                            sensor_present;
    logic                            window_closed;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [opd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [opd_pkg::CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int cycle_count;
    int src_idle_pct;
    int sink_idle_pct;
    logic cur_asleep;

    obstruction_pulse_detector u_dut (.*);
    opd_checker u_chk (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_req(input logic cmd, input logic lvl, input logic tick,
                            input logic rep);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= cmd;
        line_level     <= lvl;
        ms_tick        <= tick;
        reported_state <= rep;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Hold off until every outstanding request has its result.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [opd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [opd_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_config(input logic [9:0] period, input logic [7:0] pmin,
                              input logic [15:0] obs_after, input logic asleep);
        logic [15:0] junk;
        junk = 16'($urandom);
        drain();
        // unused upper data bits carry noise
        write_reg(opd_pkg::REG_CHECK_PERIOD, {junk[15:10], period});
        write_reg(opd_pkg::REG_PULSE_MIN, {junk[7:0], pmin});
        write_reg(opd_pkg::REG_OBSTRUCTED_AFT, obs_after);
        write_reg(opd_pkg::REG_ASLEEP_LEVEL, {junk[15:1], asleep});
        cfg_valid  <= 1'b0;
        cur_asleep  = asleep;
    endtask

    task automatic run_random(input int count);
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(99);
            len  = $urandom_range(5, 40);
            if (kind < 8)
            begin
                send_req(opd_pkg::CMD_REPORT, 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                for (int i = 0; i < len && sent < count; i++)
                begin
                    if (kind < 40)       // pulsing beam, mostly high with short lows
                        send_req(opd_pkg::CMD_SAMPLE, $urandom_range(3) != 0,
                                 $urandom_range(3) == 0, 1'($urandom_range(1)));
                    else if (kind < 62)  // awake and steady
                        send_req(opd_pkg::CMD_SAMPLE, ~cur_asleep,
                                 $urandom_range(3) != 0, 1'($urandom_range(1)));
                    else if (kind < 82)  // asleep
                        send_req(opd_pkg::CMD_SAMPLE, cur_asleep,
                                 $urandom_range(3) != 0, 1'($urandom_range(1)));
                    else
                        send_req(opd_pkg::CMD_SAMPLE, 1'($urandom_range(1)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        logic [9:0]  r_period;
        logic [7:0]  r_pmin;
        logic [15:0] r_obs;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = opd_pkg::CMD_SAMPLE;
        line_level     = 1'b1;
        ms_tick        = 1'b0;
        reported_state = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = opd_pkg::REG_CHECK_PERIOD;
        cfg_data       = '0;
        src_idle_pct   = 33;
        sink_idle_pct  = 73;
        cur_asleep     = opd_pkg::ASLEEP_LEVEL_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reports before any sensor is seen; line and tick fields are ignored
        send_req(opd_pkg::CMD_REPORT, 1'b0, 1'b1, 1'b0);
        send_req(opd_pkg::CMD_REPORT, 1'b1, 1'b0, 1'b1);
        send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b0, 1'b0);

        set_config(10'd1, 8'd0, 16'd0, 1'b0);
        send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b0);
        send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b1);   // steady awake: obstructed
        send_req(opd_pkg::CMD_SAMPLE, 1'b0, 1'b0, 1'b0);
        send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b0);
        send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b0);   // one edge over zero: clear
        send_req(opd_pkg::CMD_REPORT, 1'b1, 1'b1, 1'b1);   // report ignored, sensor present
        repeat (4) send_req(opd_pkg::CMD_SAMPLE, 1'b0, 1'b1, 1'b0);

        // lowered period closes the window on a sample without a tick
        set_config(10'd3, 8'd255, 16'd65535, 1'b1);
        repeat (3) send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b0);
        set_config(10'd1, 8'd0, 16'd0, 1'b1);
        send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b0, 1'b0);
        send_req(opd_pkg::CMD_SAMPLE, 1'b0, 1'b1, 1'b1);
        send_req(opd_pkg::CMD_SAMPLE, 1'b0, 1'b1, 1'b0);

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 73 : 0;
            sink_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 33 : 0;
            for (int k = 0; k < 4; k++)
            begin
                case ($urandom_range(9))
                    0:       r_period = 10'd1023;
                    1:       r_period = 10'd1;
                    default: r_period = 10'($urandom_range(1, 8));
                endcase
                case ($urandom_range(9))
                    0:       r_pmin = 8'd255;
                    1:       r_pmin = 8'd0;
                    default: r_pmin = 8'($urandom_range(0, 4));
                endcase
                case ($urandom_range(9))
                    0:       r_obs = 16'd65535;
                    1:       r_obs = 16'd0;
                    default: r_obs = 16'($urandom_range(0, 40));
                endcase
                set_config(r_period, r_pmin, r_obs, 1'($urandom_range(1)));
                run_random(32);
                drain();
                run_random(32);
            end
        end

        // edge counter saturation: the counter stops at 255, which does not exceed a minimum of 255 but exceeds 254
        set_config(10'd2, 8'd255, 16'd0, 1'b0);
        repeat (3) send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b0);
        repeat (260)
        begin
            send_req(opd_pkg::CMD_SAMPLE, 1'b0, 1'b0, 1'b0);
            send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b0, 1'b0);
        end
        repeat (3) send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b0);
        set_config(10'd2, 8'd254, 16'd0, 1'b0);
        repeat (260)
        begin
            send_req(opd_pkg::CMD_SAMPLE, 1'b0, 1'b0, 1'b0);
            send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b0, 1'b0);
        end
        repeat (3) send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b0);

        // largest period holds the window open; a lowered one then closes it
        set_config(10'd1023, 8'd255, 16'd65535, 1'b0);
        repeat (40) send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b0);
        set_config(10'd1, 8'd0, 16'd65535, 1'b0);
        send_req(opd_pkg::CMD_SAMPLE, 1'b0, 1'b0, 1'b0);
        repeat (2) send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b0);
        repeat (2) send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b0);
        set_config(10'd1, 8'd0, 16'd65534, 1'b0);
        repeat (2) send_req(opd_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b0);

        drain();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
